// ===== sv/stfw_pkg.sv =====
// Shared types and constants for the stream to flash image writer.
// No dependencies; used by the top level.
package stfw_pkg;

   // Result kinds
   localparam logic [1:0] KIND_ERASE  = 2'd0;
   localparam logic [1:0] KIND_PROG   = 2'd1;
   localparam logic [1:0] KIND_VOLUME = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // Configuration register indexes
   localparam logic CSR_INFO_SECTOR = 1'b0;
   localparam logic CSR_IMAGE_START = 1'b1;

   localparam logic [23:0] INFO_SECTOR_RESET = 24'h000000;
   localparam logic [23:0] IMAGE_START_RESET = 24'h001000;

   // Flash sector geometry (4 KiB sectors)
   localparam int SECTOR_OFFSET_W = 12;

   // Header decode
   localparam logic [7:0]  CMD_PREFIX     = 8'hFF;
   localparam logic [7:0]  CMD_SET_VOLUME = 8'h01;
   localparam logic [32:0] HEADER_BYTES   = 33'd4;

   // Info block words, bytes packed little-endian
   localparam logic [31:0] MARK_START_WORD = 32'h00FF_00FF;  // FF 00 FF 00
   localparam logic [31:0] MARK_DONE_WORD  = 32'hAA55_1FF1;  // F1 1F 55 AA
   localparam logic [31:0] INFO_PAD_WORD   = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_DROP   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_INFO_ERASE,
      SQ_INFO_PROG,
      SQ_CHUNK_START,
      SQ_CHUNK_ERASE,
      SQ_CHUNK_PROG,
      SQ_DONE
   } seq_type;

endpackage

// ===== sv/stfw_req_if.sv =====
// Byte input channel of the flash image writer.
// No dependencies.
interface stfw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_end;

   modport source (output valid, output data_byte, output packet_end, input ready);
   modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

// ===== sv/stfw_rsp_if.sv =====
// Flash command output channel of the flash image writer.
// No dependencies.
interface stfw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [23:0] flash_address;
   logic [31:0] program_word;
   logic [7:0]  volume;
   logic        last_of_run;

   modport source (output valid, output kind, output flash_address, output program_word,
                   output volume, output last_of_run, input ready);
   modport sink   (input valid, input kind, input flash_address, input program_word,
                   input volume, input last_of_run, output ready);
endinterface

// ===== sv/stfw_chunk_ram.sv =====
// Chunk buffer: word-wide synchronous RAM with a byte write port and a
// registered word read port. No dependencies.
module stfw_chunk_ram #(
   parameter int WORDS = 16,
   parameter int WW    = $clog2(WORDS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [WW-1:0] wr_word,
   input  logic [1:0]    wr_lane,
   input  logic [7:0]    wr_data,
   input  logic [WW-1:0] rd_word,
   output logic [31:0]   rd_data
);

   logic [31:0] ram_mem [WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_mem[wr_word][8*wr_lane +: 8] <= wr_data;
      end
      // read-before-write on the same edge
      rd_data_ff <= ram_mem[rd_word];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/stream_to_flash_image_writer_top.sv =====
// Top level of the stream to flash image writer.
// Depends on stfw_pkg, stfw_req_if, stfw_rsp_if and stfw_chunk_ram.
//
// Usage: bytes enter on req (valid/ready, data_byte, packet_end); flash
// commands leave on rsp (kind, flash_address, program_word, volume,
// last_of_run), one item per handshake. csr_we/csr_index/csr_wdata set the
// info sector and image start addresses; the user writes them only while
// the block is idle, as the block does not enforce it. A byte that causes
// no command leaves the block idle, so plain data bytes stream at one per
// cycle while the output register is free. A byte that causes commands
// takes the block busy (req.ready low) while its run is issued, one item
// per cycle from the output register unless rsp.ready stalls it: an info
// write is 1 + ceil(CHUNK_BYTES/4) items, a chunk write is a setup state,
// an optional erase and ceil(CHUNK_BYTES/4) program items, the done item
// one more. Program words come from the chunk RAM's single read port, one
// word per cycle; a volume item appears the cycle after its byte is taken.
// Reset returns the sequencer to idle, waits for a size header and loads
// the register reset values; no clearing pass is needed, since a fill
// high-water mark makes never-written chunk bytes read as zero.
// When rsp.ready is low the output register holds its item, the run pauses
// and req.ready stays low until the slot frees.
module stream_to_flash_image_writer_top #(
   parameter int CHUNK_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   stfw_req_if.sink          req,
   stfw_rsp_if.source        rsp,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [23:0]       csr_wdata
);

   localparam int WORDS = (CHUNK_BYTES + 3) / 4;
   localparam int WW    = $clog2(WORDS);
   localparam int FW    = $clog2(CHUNK_BYTES);
   localparam int HW    = FW + 1;
   localparam int CMPW  = FW + 2;

   // configuration
   logic [23:0] info_sector_ff, info_sector_in;
   logic [23:0] image_start_ff, image_start_in;

   // transfer state
   stfw_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  hc_ff, hc_in;
   logic [7:0]  hb_ff [4];
   logic [7:0]  hb_in [4];
   logic [31:0] size_ff, size_in;
   logic [32:0] total_ff, total_in;
   logic [23:0] waddr_ff, waddr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [HW-1:0] hwm_ff, hwm_in;
   logic [23:0] chunk_base_ff, chunk_base_in;

   // sequencer
   stfw_pkg::seq_type seq_ff, seq_in;
   logic [WW-1:0] w_ff, w_in;
   logic info_start_ff, info_start_in;
   logic chunk_ff, chunk_in;
   logic finish_ff, finish_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [23:0] rsp_addr_ff;
   logic [31:0] rsp_word_ff;
   logic [7:0]  rsp_vol_ff;
   logic        rsp_last_ff;

   logic accept, out_free, out_load, word_last;
   logic dec_info_start, dec_chunk, dec_finish, dec_volume, mem_we;
   logic [HW-1:0] fill_next;
   logic [32:0]   total_inc;
   logic          chunk_full, complete;
   logic [23:0]   info_base, word_off;
   logic [31:0]   ram_rdata, chunk_word, info_word;
   logic          item_emit, item_last;
   logic [1:0]    item_kind;
   logic [23:0]   item_addr;
   logic [31:0]   item_word;
   logic [7:0]    item_vol;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (seq_ff == stfw_pkg::SQ_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign out_load  = item_emit && out_free;
   assign word_last = (w_ff == WW'(WORDS - 1));

   assign info_base = {info_sector_ff[23:stfw_pkg::SECTOR_OFFSET_W],
                       {stfw_pkg::SECTOR_OFFSET_W{1'b0}}};
   assign word_off  = 24'({w_ff, 2'b00});

   assign fill_next  = HW'(fill_ff) + HW'(1);
   assign chunk_full = (fill_next == HW'(CHUNK_BYTES));
   assign total_inc  = (total_ff == '1) ? total_ff : total_ff + 33'd1;
   assign complete   = ({1'b0, size_ff} + stfw_pkg::HEADER_BYTES) <= total_inc;

   //------------------------------------------------------------------
   // Chunk buffer
   //------------------------------------------------------------------
   stfw_chunk_ram #(
      .WORDS (WORDS),
      .WW    (WW)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_word (WW'(fill_ff >> 2)),
      .wr_lane (fill_ff[1:0]),
      .wr_data (req.data_byte),
      .rd_word (w_in),
      .rd_data (ram_rdata)
   );

   // bytes past the high-water mark were never written: read them as zero
   always_comb begin : chunk_mask
      logic [CMPW-1:0] idx;
      idx = '0;
      for (int k = 0; k < 4; k++) begin
         idx = CMPW'({w_ff, 2'b00}) + CMPW'(k);
         chunk_word[8*k +: 8] = (idx < CMPW'(hwm_ff)) ? ram_rdata[8*k +: 8] : 8'h00;
      end
   end

   always_comb begin : info_select
      if (w_ff == '0) begin
         info_word = {hb_ff[3], hb_ff[2], hb_ff[1], hb_ff[0]};
      end else if (w_ff == WW'(1)) begin
         info_word = info_start_ff ? stfw_pkg::MARK_START_WORD : stfw_pkg::MARK_DONE_WORD;
      end else begin
         info_word = stfw_pkg::INFO_PAD_WORD;
      end
   end

   //------------------------------------------------------------------
   // Configuration
   //------------------------------------------------------------------
   always_comb begin : csr_write
      info_sector_in = info_sector_ff;
      image_start_in = image_start_ff;
      if (csr_we) begin
         unique case (csr_index)
            stfw_pkg::CSR_INFO_SECTOR: info_sector_in = csr_wdata;
            stfw_pkg::CSR_IMAGE_START: image_start_in = csr_wdata;
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------
   // Byte decode: all transfer state advances when the item is taken
   //------------------------------------------------------------------
   always_comb begin : decode
      phase_in      = phase_ff;
      hc_in         = hc_ff;
      hb_in         = hb_ff;
      size_in       = size_ff;
      total_in      = total_ff;
      waddr_in      = waddr_ff;
      fill_in       = fill_ff;
      hwm_in        = hwm_ff;
      chunk_base_in = chunk_base_ff;
      dec_info_start = 1'b0;
      dec_chunk      = 1'b0;
      dec_finish     = 1'b0;
      dec_volume     = 1'b0;
      mem_we         = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            stfw_pkg::PH_DROP: begin
               if (req.packet_end) phase_in = stfw_pkg::PH_HEADER;
            end
            stfw_pkg::PH_DATA: begin
               mem_we   = 1'b1;
               total_in = total_inc;
               hwm_in   = (fill_next > hwm_ff) ? fill_next : hwm_ff;
               fill_in  = fill_next[FW-1:0];
               if (chunk_full) begin
                  dec_chunk     = 1'b1;
                  chunk_base_in = waddr_ff;
                  waddr_in      = waddr_ff + 24'(CHUNK_BYTES);
                  fill_in       = '0;
               end
               if (req.packet_end && complete) begin
                  // partial chunk unless the full flush just emptied it
                  dec_chunk     = 1'b1;
                  chunk_base_in = waddr_ff;
                  dec_finish    = 1'b1;
                  phase_in      = stfw_pkg::PH_HEADER;
                  hc_in         = '0;
                  fill_in       = '0;
               end
            end
            default: begin
               hb_in[hc_ff] = req.data_byte;
               if (hc_ff == 2'd3) begin
                  hc_in = '0;
                  if (hb_ff[0] == stfw_pkg::CMD_PREFIX && hb_ff[1] == stfw_pkg::CMD_PREFIX) begin
                     dec_volume = (hb_ff[2] == stfw_pkg::CMD_SET_VOLUME);
                     phase_in   = req.packet_end ? stfw_pkg::PH_HEADER : stfw_pkg::PH_DROP;
                  end else begin
                     size_in        = {hb_ff[0], hb_ff[1], hb_ff[2], req.data_byte};
                     dec_info_start = 1'b1;
                     waddr_in       = image_start_ff;
                     fill_in        = '0;
                     total_in       = stfw_pkg::HEADER_BYTES;
                     phase_in       = stfw_pkg::PH_DATA;
                     if (req.packet_end && size_in == '0) begin
                        dec_finish = 1'b1;
                        phase_in   = stfw_pkg::PH_HEADER;
                     end
                  end
               end else begin
                  hc_in = hc_ff + 2'd1;
               end
            end
         endcase
      end
   end

   //------------------------------------------------------------------
   // Sequencer: next state
   //------------------------------------------------------------------
   always_comb begin : seq_next
      seq_in = seq_ff;
      unique case (seq_ff)
         stfw_pkg::SQ_IDLE: begin
            if (accept) begin
               if (dec_info_start)  seq_in = stfw_pkg::SQ_INFO_ERASE;
               else if (dec_chunk)  seq_in = stfw_pkg::SQ_CHUNK_START;
               else if (dec_finish) seq_in = stfw_pkg::SQ_INFO_ERASE;
            end
         end
         stfw_pkg::SQ_INFO_ERASE: begin
            if (out_free) seq_in = stfw_pkg::SQ_INFO_PROG;
         end
         stfw_pkg::SQ_INFO_PROG: begin
            if (out_free && word_last) begin
               if (!info_start_ff)  seq_in = stfw_pkg::SQ_DONE;
               else if (chunk_ff)   seq_in = stfw_pkg::SQ_CHUNK_START;
               else if (finish_ff)  seq_in = stfw_pkg::SQ_INFO_ERASE;
               else                 seq_in = stfw_pkg::SQ_IDLE;
            end
         end
         stfw_pkg::SQ_CHUNK_START: begin
            // this setup state lets the RAM read see the byte just written
            if (chunk_base_ff[stfw_pkg::SECTOR_OFFSET_W-1:0] == '0) begin
               seq_in = stfw_pkg::SQ_CHUNK_ERASE;
            end else begin
               seq_in = stfw_pkg::SQ_CHUNK_PROG;
            end
         end
         stfw_pkg::SQ_CHUNK_ERASE: begin
            if (out_free) seq_in = stfw_pkg::SQ_CHUNK_PROG;
         end
         stfw_pkg::SQ_CHUNK_PROG: begin
            if (out_free && word_last) begin
               seq_in = finish_ff ? stfw_pkg::SQ_INFO_ERASE : stfw_pkg::SQ_IDLE;
            end
         end
         stfw_pkg::SQ_DONE: begin
            if (out_free) seq_in = stfw_pkg::SQ_IDLE;
         end
         default: seq_in = stfw_pkg::SQ_IDLE;
      endcase
   end

   //------------------------------------------------------------------
   // Sequencer: items
   //------------------------------------------------------------------
   always_comb begin : seq_out
      item_emit = 1'b0;
      item_kind = stfw_pkg::KIND_ERASE;
      item_addr = '0;
      item_word = '0;
      item_vol  = '0;
      item_last = 1'b0;
      unique case (seq_ff)
         stfw_pkg::SQ_IDLE: begin
            item_emit = accept && dec_volume;
            item_kind = stfw_pkg::KIND_VOLUME;
            item_vol  = req.data_byte;
            item_last = 1'b1;
         end
         stfw_pkg::SQ_INFO_ERASE: begin
            item_emit = 1'b1;
            item_addr = info_base;
         end
         stfw_pkg::SQ_INFO_PROG: begin
            item_emit = 1'b1;
            item_kind = stfw_pkg::KIND_PROG;
            item_addr = info_base + word_off;
            item_word = info_word;
            item_last = word_last && info_start_ff && !chunk_ff && !finish_ff;
         end
         stfw_pkg::SQ_CHUNK_START: ;
         stfw_pkg::SQ_CHUNK_ERASE: begin
            item_emit = 1'b1;
            item_addr = chunk_base_ff;
         end
         stfw_pkg::SQ_CHUNK_PROG: begin
            item_emit = 1'b1;
            item_kind = stfw_pkg::KIND_PROG;
            item_addr = chunk_base_ff + word_off;
            item_word = chunk_word;
            item_last = word_last && !finish_ff;
         end
         stfw_pkg::SQ_DONE: begin
            item_emit = 1'b1;
            item_kind = stfw_pkg::KIND_DONE;
            item_last = 1'b1;
         end
         default: ;
      endcase
   end

   // word counter rests at zero between program runs
   always_comb begin : word_count
      w_in = w_ff;
      if ((seq_ff == stfw_pkg::SQ_INFO_PROG || seq_ff == stfw_pkg::SQ_CHUNK_PROG) && out_free) begin
         w_in = word_last ? '0 : w_ff + WW'(1);
      end
   end

   always_comb begin : run_flags
      info_start_in = info_start_ff;
      chunk_in      = chunk_ff;
      finish_in     = finish_ff;
      if (accept) begin
         info_start_in = dec_info_start;
         chunk_in      = dec_chunk;
         finish_in     = dec_finish;
      end else begin
         if (seq_ff == stfw_pkg::SQ_INFO_PROG && out_free && word_last) info_start_in = 1'b0;
         if (seq_ff == stfw_pkg::SQ_CHUNK_PROG && out_free && word_last) chunk_in = 1'b0;
         if (seq_ff == stfw_pkg::SQ_DONE && out_free) finish_in = 1'b0;
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   //------------------------------------------------------------------
   // Registers
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         info_sector_ff <= stfw_pkg::INFO_SECTOR_RESET;
         image_start_ff <= stfw_pkg::IMAGE_START_RESET;
         phase_ff       <= stfw_pkg::PH_HEADER;
         hc_ff          <= '0;
         hb_ff          <= '{default: 8'h00};
         size_ff        <= '0;
         total_ff       <= '0;
         waddr_ff       <= '0;
         fill_ff        <= '0;
         hwm_ff         <= '0;
         seq_ff         <= stfw_pkg::SQ_IDLE;
         w_ff           <= '0;
         info_start_ff  <= 1'b0;
         chunk_ff       <= 1'b0;
         finish_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         info_sector_ff <= info_sector_in;
         image_start_ff <= image_start_in;
         phase_ff       <= phase_in;
         hc_ff          <= hc_in;
         hb_ff          <= hb_in;
         size_ff        <= size_in;
         total_ff       <= total_in;
         waddr_ff       <= waddr_in;
         fill_ff        <= fill_in;
         hwm_ff         <= hwm_in;
         seq_ff         <= seq_in;
         w_ff           <= w_in;
         info_start_ff  <= info_start_in;
         chunk_ff       <= chunk_in;
         finish_ff      <= finish_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_base_ff <= chunk_base_in;
      if (out_load) begin
         rsp_kind_ff <= item_kind;
         rsp_addr_ff <= item_addr;
         rsp_word_ff <= item_word;
         rsp_vol_ff  <= item_vol;
         rsp_last_ff <= item_last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = rsp_kind_ff;
   assign rsp.flash_address = rsp_addr_ff;
   assign rsp.program_word  = rsp_word_ff;
   assign rsp.volume        = rsp_vol_ff;
   assign rsp.last_of_run   = rsp_last_ff;

`ifndef ASSERT_OFF
   a_word_rest: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != stfw_pkg::SQ_INFO_PROG && seq_ff != stfw_pkg::SQ_CHUNK_PROG) |-> (w_ff == '0))
      else $error("word counter not at rest outside a program run");

   a_fill_mark: assert property (@(posedge clock) disable iff (reset)
      HW'(fill_ff) <= hwm_ff)
      else $error("chunk fill ahead of the high-water mark");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && item_last) |=> (seq_ff == stfw_pkg::SQ_IDLE && !finish_ff))
      else $error("run continues after its last item");

   a_chunk_flag: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == stfw_pkg::SQ_CHUNK_START || seq_ff == stfw_pkg::SQ_CHUNK_ERASE ||
       seq_ff == stfw_pkg::SQ_CHUNK_PROG) |-> chunk_ff)
      else $error("chunk write without a pending chunk");
`endif

endmodule
